@@ sv/steering_pd_motor_controller_assert.svh @@
// assertion macros for the steering pd motor controller
// used by the top level only, expects clk and rst_n in scope
`ifndef STEERING_PD_MOTOR_CONTROLLER_ASSERT_SVH
`define STEERING_PD_MOTOR_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SPDMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPDMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/spdmc_pkg.sv @@
// shared types and constants for the steering pd motor controller
// no dependencies; imported by every module of the block
package spdmc_pkg;

  localparam int SPEED_W = 10;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_SPEED_FLOOR = 2'd0;
  localparam logic [1:0] CFG_SPEED_CEIL  = 2'd1;
  localparam logic [1:0] CFG_BASE_SPEED  = 2'd2;
  localparam logic [1:0] CFG_FIXED_PWM   = 2'd3;

  localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR = 10'd10;
  localparam logic [SPEED_W-1:0] RST_SPEED_CEIL  = 10'd300;
  localparam logic [SPEED_W-1:0] RST_BASE_SPEED  = 10'd250;
  localparam logic [SPEED_W-1:0] RST_FIXED_PWM   = 10'd380;
  localparam logic [7:0]         RST_GAIN        = 8'd10;

  // frame bytes
  localparam logic [7:0] GAIN_P_BYTE = 8'h07;
  localparam logic [7:0] GAIN_D_BYTE = 8'h08;
  localparam logic [3:0] FRAME_LAST  = 4'd8;

  // pending gain codes
  localparam logic [1:0] GP_NONE = 2'd0;
  localparam logic [1:0] GP_P    = 2'd1;
  localparam logic [1:0] GP_D    = 2'd2;

  // direction modes
  localparam logic [7:0] MODE_STOP       = 8'd0;
  localparam logic [7:0] MODE_SPIN_LEFT  = 8'd1;
  localparam logic [7:0] MODE_SPIN_RIGHT = 8'd2;
  localparam logic [7:0] MODE_FORWARD    = 8'd3;
  localparam logic [7:0] MODE_REVERSE    = 8'd4;
  localparam logic [7:0] MODE_GRIP_OPEN  = 8'd5;
  localparam logic [7:0] MODE_GRIP_CLOSE = 8'd6;

  localparam logic [1:0] PINS_SPIN_LEFT  = 2'b10;
  localparam logic [1:0] PINS_SPIN_RIGHT = 2'b01;
  localparam logic [1:0] PINS_FORWARD    = 2'b11;
  localparam logic [1:0] PINS_REVERSE    = 2'b00;

  localparam logic [7:0] GRIP_OPEN   = 8'd9;
  localparam logic [7:0] GRIP_CLOSED = 8'd12;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PGAIN,
    OP_DGAIN,
    OP_MODE,
    OP_SENS_HI,
    OP_SENS_LO,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [1:0] idx;
    logic [7:0] data;
    logic       done;
  } q_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_floor;
    logic [SPEED_W-1:0] speed_ceil;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] fixed_pwm;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic res_we;
  } back_stat_t;

endpackage

@@ sv/steering_pd_motor_controller.sv @@
// top level of the steering pd motor controller: config registers, parser,
// queue and execution unit; depends on spdmc_pkg and the assertion header
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | command, data_byte
//   out     | output    | out_valid/out_stall| left/right drive, pins, gripper, frame done
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// the execution unit handles a serial byte in its idle state; a tick steps through the error terms,
// p product, d product and speed update, sharing the one multiplier
// the parser takes a transfer every cycle while the queue has room
// reset is synchronous; after reset the block takes transfers at once
// a stalled result holds the execution unit, which then fills the queue and stalls the input
`include "steering_pd_motor_controller_assert.svh"

module steering_pd_motor_controller #(
  parameter int SENSOR_WIDTH = 16,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_left_drive,
  output logic [9:0] out_right_drive,
  output logic [1:0] out_direction_pins,
  output logic [7:0] out_gripper_position,
  output logic       out_frame_complete,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata
);
  import spdmc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t       cfg_r;
  logic       push, q_full, q_pop, q_valid;
  q_item_t    push_item, q_item;
  logic [CNT_W-1:0] q_count;
  back_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_floor <= RST_SPEED_FLOOR;
      cfg_r.speed_ceil  <= RST_SPEED_CEIL;
      cfg_r.base_speed  <= RST_BASE_SPEED;
      cfg_r.fixed_pwm   <= RST_FIXED_PWM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPEED_FLOOR: cfg_r.speed_floor <= cfg_wdata;
        CFG_SPEED_CEIL:  cfg_r.speed_ceil  <= cfg_wdata;
        CFG_BASE_SPEED:  cfg_r.base_speed  <= cfg_wdata;
        CFG_FIXED_PWM:   cfg_r.fixed_pwm   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  spdmc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  spdmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .count     (q_count)
  );

  spdmc_back #(
    .SENSOR_WIDTH (SENSOR_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_left_drive       (out_left_drive),
    .out_right_drive      (out_right_drive),
    .out_direction_pins   (out_direction_pins),
    .out_gripper_position (out_gripper_position),
    .out_frame_complete   (out_frame_complete),
    .stat                 (stat)
  );

  // queue bookkeeping and result slot checks
  `SPDMC_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `SPDMC_ASSERT_IMPL(a_pop_nonempty, q_pop, q_count != '0, "pop from empty queue")
  `SPDMC_ASSERT_IMPL(a_write_free, stat.res_we, !out_valid || !out_stall, "result overwrites a stalled transfer")
  `SPDMC_ASSERT_NEXT(a_no_phantom, stat.idle && q_count == '0, !$rose(out_valid), "result with no work")

endmodule

@@ sv/spdmc_front.sv @@
// front end: frame parser that turns each accepted item into a queued operation
// depends on spdmc_pkg
module spdmc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              push,
  output spdmc_pkg::q_item_t push_item
);
  import spdmc_pkg::*;

  logic [3:0] frame_pos_r, frame_pos_nxt;
  logic [1:0] gain_pend_r, gain_pend_nxt;
  logic [3:0] pos;
  logic [3:0] pos_m1;

  assign push = in_valid && !q_full;

  always_comb begin
    pos       = (frame_pos_r > FRAME_LAST) ? 4'd0 : frame_pos_r;
    pos_m1    = pos - 4'd1;
    push_item = '{kind: OP_NONE, idx: pos_m1[2:1], data: in_data_byte, done: 1'b0};
    frame_pos_nxt = frame_pos_r;
    gain_pend_nxt = gain_pend_r;
    if (in_command) begin
      push_item.kind = OP_TICK;
    end else if (gain_pend_r == GP_P || gain_pend_r == GP_D) begin
      push_item.kind = (gain_pend_r == GP_P) ? OP_PGAIN : OP_DGAIN;
      gain_pend_nxt  = GP_NONE;
      frame_pos_nxt  = pos;
    end else if (pos == 4'd0 && (in_data_byte == GAIN_P_BYTE || in_data_byte == GAIN_D_BYTE)) begin
      gain_pend_nxt = (in_data_byte == GAIN_P_BYTE) ? GP_P : GP_D;
      frame_pos_nxt = 4'd0;
    end else if (pos == 4'd0) begin
      push_item.kind = OP_MODE;
      gain_pend_nxt  = GP_NONE;
      frame_pos_nxt  = 4'd1;
    end else begin
      // odd positions carry the high byte of a reading
      push_item.kind = pos[0] ? OP_SENS_HI : OP_SENS_LO;
      gain_pend_nxt  = GP_NONE;
      if (pos == FRAME_LAST) begin
        push_item.done = 1'b1;
        frame_pos_nxt  = 4'd0;
      end else begin
        frame_pos_nxt = pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pos_r <= 4'd0;
      gain_pend_r <= GP_NONE;
    end else if (push) begin
      frame_pos_r <= frame_pos_nxt;
      gain_pend_r <= gain_pend_nxt;
    end
  end

endmodule

@@ sv/spdmc_queue.sv @@
// short register queue between the parser and the execution unit
// depends on spdmc_pkg
module spdmc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spdmc_pkg::q_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output spdmc_pkg::q_item_t q_item,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import spdmc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_item_t           mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign count   = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/spdmc_back.sv @@
// back end: executes queued operations, pd tick on one shared multiplier
// depends on spdmc_pkg
module spdmc_back #(
  parameter int SENSOR_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spdmc_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  spdmc_pkg::q_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_left_drive,
  output logic [9:0]          out_right_drive,
  output logic [1:0]          out_direction_pins,
  output logic [7:0]          out_gripper_position,
  output logic                out_frame_complete,
  output spdmc_pkg::back_stat_t stat
);
  import spdmc_pkg::*;

  localparam int EW = SENSOR_WIDTH + 2; // error and derivative
  localparam int PW = EW + 9;           // gain times error
  localparam int OW = PW + 2;           // twice the control term
  localparam int VW = OW + 2;           // twice a wheel speed after the move

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MULP = 4'b0010,
    ST_MULD = 4'b0100,
    ST_UPD  = 4'b1000
  } st_t;

  st_t st_r, st_nxt;

  logic [7:0]              prop_r, prop_nxt;
  logic [7:0]              deriv_r, deriv_nxt;
  logic [7:0]              mode_r, mode_nxt;
  logic [SENSOR_WIDTH-1:0] sens_r [4];
  logic [SENSOR_WIDTH-1:0] sens_nxt [4];
  logic [SPEED_W-1:0]      left_r, left_nxt, right_r, right_nxt;
  logic [SPEED_W-1:0]      drv_l_r, drv_l_nxt, drv_r_r, drv_r_nxt;
  logic [1:0]              pins_r, pins_nxt;
  logic [7:0]              grip_r, grip_nxt;
  logic                    out_valid_r;

  logic signed [EW-1:0] e2_r, e2_nxt, dd_r, dd_nxt, e2_w, dd_w;
  logic signed [PW-1:0] prod_p_r, prod_p_nxt, prod_d_r, prod_d_nxt, prod_w;
  logic signed [8:0]    mul_a;
  logic signed [EW-1:0] mul_b;
  logic signed [OW-1:0] o2_w;
  logic signed [VW-1:0] lv_w, rv_w;
  logic [EW-1:0]        fl_x, fr_x, bl_x, br_x;
  logic                 e2_pos;
  logic [15:0]          hi16, lo16;
  logic                 out_free, res_we, res_done;
  logic [SPEED_W-1:0]   lnew, rnew;

  logic [SPEED_W-1:0]   o_left_r, o_right_r;
  logic [1:0]           o_pins_r;
  logic [7:0]           o_grip_r;
  logic                 o_done_r;

  // half of v rounded down, then clamped; any negative v lands on the lower clamp
  function automatic logic [SPEED_W-1:0] clamp_half(input logic signed [VW-1:0] v,
                                                    input logic [SPEED_W-1:0] lo,
                                                    input logic [SPEED_W-1:0] hi);
    logic [VW-2:0] h;
    h = v[VW-1:1];
    if (v[VW-1]) begin
      return lo;
    end else if (h < (VW-1)'(lo)) begin
      return lo;
    end else if (h > (VW-1)'(hi)) begin
      return hi;
    end else begin
      return h[SPEED_W-1:0];
    end
  endfunction

  assign out_free = !out_valid_r || !out_stall;

  // error terms straight from the sensor registers
  assign fl_x   = EW'(sens_r[0]);
  assign fr_x   = EW'(sens_r[1]);
  assign bl_x   = EW'(sens_r[2]);
  assign br_x   = EW'(sens_r[3]);
  assign e2_w   = $signed((fl_x + bl_x) - (fr_x + br_x));
  assign e2_pos = !e2_w[EW-1] && (e2_w != '0);
  assign dd_w   = e2_pos ? $signed(fr_x - br_x) : $signed(fl_x - bl_x);

  // shared multiplier: p term first, d term next cycle
  assign mul_a  = (st_r == ST_MULP) ? $signed({1'b0, prop_r}) : $signed({1'b0, deriv_r});
  assign mul_b  = (st_r == ST_MULP) ? e2_r : dd_r;
  assign prod_w = mul_a * mul_b;

  assign o2_w = OW'(prod_p_r) + (OW'(prod_d_r) <<< 1);
  assign lv_w = VW'($signed({1'b0, left_r, 1'b0})) - VW'(o2_w);
  assign rv_w = VW'($signed({1'b0, right_r, 1'b0})) + VW'(o2_w);
  assign lnew = (o2_w != '0) ? clamp_half(lv_w, cfg.speed_floor, cfg.speed_ceil) : left_r;
  assign rnew = (o2_w != '0) ? clamp_half(rv_w, cfg.speed_floor, cfg.speed_ceil) : right_r;

  assign hi16 = {q_item.data, 8'h00};
  assign lo16 = {8'h00, q_item.data};

  always_comb begin
    st_nxt     = st_r;
    prop_nxt   = prop_r;
    deriv_nxt  = deriv_r;
    mode_nxt   = mode_r;
    sens_nxt   = sens_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    drv_l_nxt  = drv_l_r;
    drv_r_nxt  = drv_r_r;
    pins_nxt   = pins_r;
    grip_nxt   = grip_r;
    e2_nxt     = e2_r;
    dd_nxt     = dd_r;
    prod_p_nxt = prod_p_r;
    prod_d_nxt = prod_d_r;
    q_pop      = 1'b0;
    res_we     = 1'b0;
    res_done   = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == OP_TICK) begin
            q_pop  = 1'b1;
            e2_nxt = e2_w;
            dd_nxt = dd_w;
            st_nxt = ST_MULP;
          end else if (out_free) begin
            q_pop    = 1'b1;
            res_we   = 1'b1;
            res_done = q_item.done;
            case (q_item.kind)
              OP_PGAIN: begin
                prop_nxt  = q_item.data;
                left_nxt  = cfg.base_speed;
                right_nxt = cfg.base_speed;
              end
              OP_DGAIN: begin
                deriv_nxt = q_item.data;
                left_nxt  = cfg.base_speed;
                right_nxt = cfg.base_speed;
              end
              OP_MODE:    mode_nxt = q_item.data;
              OP_SENS_HI: sens_nxt[q_item.idx] = hi16[SENSOR_WIDTH-1:0];
              OP_SENS_LO: sens_nxt[q_item.idx] = sens_r[q_item.idx] | lo16[SENSOR_WIDTH-1:0];
              default: ;
            endcase
          end
        end
      end
      ST_MULP: begin
        prod_p_nxt = prod_w;
        st_nxt     = ST_MULD;
      end
      ST_MULD: begin
        prod_d_nxt = prod_w;
        st_nxt     = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          res_we    = 1'b1;
          st_nxt    = ST_IDLE;
          left_nxt  = lnew;
          right_nxt = rnew;
          case (mode_r) inside
            MODE_STOP: begin
              drv_l_nxt = '0;
              drv_r_nxt = '0;
              left_nxt  = cfg.base_speed;
              right_nxt = cfg.base_speed;
            end
            MODE_SPIN_LEFT, MODE_SPIN_RIGHT: begin
              pins_nxt  = (mode_r == MODE_SPIN_LEFT) ? PINS_SPIN_LEFT : PINS_SPIN_RIGHT;
              drv_l_nxt = cfg.fixed_pwm;
              drv_r_nxt = cfg.fixed_pwm;
              left_nxt  = cfg.base_speed;
              right_nxt = cfg.base_speed;
            end
            MODE_FORWARD, MODE_REVERSE: begin
              pins_nxt  = (mode_r == MODE_FORWARD) ? PINS_FORWARD : PINS_REVERSE;
              drv_l_nxt = lnew;
              drv_r_nxt = rnew;
            end
            MODE_GRIP_OPEN:  grip_nxt = GRIP_OPEN;
            MODE_GRIP_CLOSE: grip_nxt = GRIP_CLOSED;
            default: ;
          endcase
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      prop_r      <= RST_GAIN;
      deriv_r     <= RST_GAIN;
      mode_r      <= MODE_STOP;
      for (int i = 0; i < 4; i++) begin
        sens_r[i] <= '0;
      end
      left_r      <= RST_BASE_SPEED;
      right_r     <= RST_BASE_SPEED;
      drv_l_r     <= '0;
      drv_r_r     <= '0;
      pins_r      <= PINS_REVERSE;
      grip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      prop_r      <= prop_nxt;
      deriv_r     <= deriv_nxt;
      mode_r      <= mode_nxt;
      sens_r      <= sens_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      drv_l_r     <= drv_l_nxt;
      drv_r_r     <= drv_r_nxt;
      pins_r      <= pins_nxt;
      grip_r      <= grip_nxt;
      out_valid_r <= res_we || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    e2_r     <= e2_nxt;
    dd_r     <= dd_nxt;
    prod_p_r <= prod_p_nxt;
    prod_d_r <= prod_d_nxt;
    if (res_we) begin
      o_left_r  <= drv_l_nxt;
      o_right_r <= drv_r_nxt;
      o_pins_r  <= pins_nxt;
      o_grip_r  <= grip_nxt;
      o_done_r  <= res_done;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_left_drive       = o_left_r;
  assign out_right_drive      = o_right_r;
  assign out_direction_pins   = o_pins_r;
  assign out_gripper_position = o_grip_r;
  assign out_frame_complete   = o_done_r;
  assign stat                 = '{idle: (st_r == ST_IDLE), res_we: res_we};

endmodule
